@@ hw/rtl/flp_pkg.sv @@
// Shared types, constants and rounding helpers for the fragment Phong lighting pipeline.
package flp_pkg;

    localparam int ISQRT_STAGES = 32;
    localparam int DIV_STAGES   = 16;
    localparam int POW_STAGES   = 8;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Normalized light direction (-1, 1, 0.5) in Q1.15
    localparam logic signed [16:0] LIGHT_X = -17'sd21845;
    localparam logic signed [16:0] LIGHT_Y = 17'sd21845;
    localparam logic signed [16:0] LIGHT_Z = 17'sd10923;

    typedef enum logic [1:0] {
        REG_AMBIENT   = 2'd0,
        REG_DIFFUSE   = 2'd1,
        REG_SPECULAR  = 2'd2,
        REG_SHININESS = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0]        v;
        logic [63:0]        r;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
    } sqrt_t;

    typedef struct packed {
        logic [47:0] rem_x;
        logic [47:0] rem_y;
        logic [47:0] rem_z;
        logic [15:0] q_x;
        logic [15:0] q_y;
        logic [15:0] q_z;
        logic [31:0] len;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic        zero;
    } div_t;

    typedef struct packed {
        logic [15:0] acc;
        logic [15:0] base;
        logic [15:0] diff;
        logic        zero;
    } pow_t;

    // shift right by 15, rounding half away from zero
    function automatic logic signed [35:0] round15(input logic signed [35:0] v);
        logic [35:0] mag;
        logic [35:0] m;
        mag = v[35] ? 36'(-v) : 36'(v);
        m   = (mag + 36'd16384) >> 15;
        return v[35] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [15:0] clamp_unit(input logic signed [35:0] v);
        logic [15:0] res;
        if (v < 0)
            res = 16'd0;
        else if (v > 36'sd32768)
            res = ONE_Q15;
        else
            res = v[15:0];
        return res;
    endfunction

    // Q.15 product rounded half up
    function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = (32'(a) * 32'(b)) + 32'd16384;
        return p[30:15];
    endfunction

endpackage

@@ hw/rtl/fragment_phong_lighting.sv @@
// Fragment Phong lighting: normalize, diffuse/specular terms, color sum, all pipelined.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | normal_x, normal_y, normal_z
//  out     | output    | out_valid/out_ready| red, green, blue, zero_normal
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One fragment per cycle unless the output stalls; stages: 2 square/sum, 32 square root,
// 17 division, 4 dot/reflect, 9 power, 1 color, then the output register.
// The root and division units set the depth: one result bit per stage.
// rst_n clears all valid bits and reloads the register defaults.
// A stall at the output freezes every stage; nothing is lost or repeated.
module fragment_phong_lighting (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  normal_x,
    input  logic signed [15:0]  normal_y,
    input  logic signed [15:0]  normal_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         red,
    output logic [15:0]         green,
    output logic [15:0]         blue,
    output logic                zero_normal,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [47:0]         cfg_data
);

    logic [47:0] ambient_reg;
    logic [47:0] diffuse_reg;
    logic [47:0] specular_reg;
    logic [7:0]  shininess_reg;

    logic adv;
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_reg   <= 48'h266626662666;
            diffuse_reg   <= 48'h266626662666;
            specular_reg  <= 48'h800080008000;
            shininess_reg <= 8'd128;
        end
        else if (cfg_valid)
        begin
            unique case (flp_pkg::cfg_reg_t'(cfg_index))
                flp_pkg::REG_AMBIENT:   ambient_reg   <= cfg_data;
                flp_pkg::REG_DIFFUSE:   diffuse_reg   <= cfg_data;
                flp_pkg::REG_SPECULAR:  specular_reg  <= cfg_data;
                flp_pkg::REG_SHININESS: shininess_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- squares ----------------
    logic               a_valid_reg;
    logic [31:0]        a_sqx_reg, a_sqy_reg, a_sqz_reg;
    logic signed [15:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sqx_reg <= 32'(normal_x * normal_x);
            a_sqy_reg <= 32'(normal_y * normal_y);
            a_sqz_reg <= 32'(normal_z * normal_z);
            a_x_reg   <= normal_x;
            a_y_reg   <= normal_y;
            a_z_reg   <= normal_z;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    flp_pkg::sqrt_t sq_reg [flp_pkg::ISQRT_STAGES+1];
    logic           sq_valid_reg [flp_pkg::ISQRT_STAGES+1];
    logic [31:0]    len2;

    assign len2 = a_sqx_reg + a_sqy_reg + a_sqz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0].v    <= {len2, 32'd0};
            sq_reg[0].r    <= 64'd0;
            sq_reg[0].x    <= a_x_reg;
            sq_reg[0].y    <= a_y_reg;
            sq_reg[0].z    <= a_z_reg;
            sq_reg[0].zero <= (len2 == 32'd0);
        end
    end

    for (genvar i = 0; i < flp_pkg::ISQRT_STAGES; i++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        flp_pkg::sqrt_t sq_next;
        logic [63:0]    trial;

        always_comb
        begin
            sq_next = sq_reg[i];
            trial   = sq_reg[i].r + BIT;
            if (sq_reg[i].v >= trial)
            begin
                sq_next.v = sq_reg[i].v - trial;
                sq_next.r = (sq_reg[i].r >> 1) + BIT;
            end
            else
            begin
                sq_next.r = sq_reg[i].r >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[i+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[i+1] <= sq_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                sq_reg[i+1] <= sq_next;
        end
    end

    // ---------------- three restoring dividers ----------------
    flp_pkg::div_t dv_reg [flp_pkg::DIV_STAGES+1];
    logic          dv_valid_reg [flp_pkg::DIV_STAGES+1];
    flp_pkg::div_t dv_init;
    logic [16:0]   mag_x, mag_y, mag_z;
    logic [31:0]   root;

    always_comb
    begin
        root  = sq_reg[flp_pkg::ISQRT_STAGES].r[31:0];
        mag_x = sq_reg[flp_pkg::ISQRT_STAGES].x[15] ?
                17'(-sq_reg[flp_pkg::ISQRT_STAGES].x) : 17'(sq_reg[flp_pkg::ISQRT_STAGES].x);
        mag_y = sq_reg[flp_pkg::ISQRT_STAGES].y[15] ?
                17'(-sq_reg[flp_pkg::ISQRT_STAGES].y) : 17'(sq_reg[flp_pkg::ISQRT_STAGES].y);
        mag_z = sq_reg[flp_pkg::ISQRT_STAGES].z[15] ?
                17'(-sq_reg[flp_pkg::ISQRT_STAGES].z) : 17'(sq_reg[flp_pkg::ISQRT_STAGES].z);
        dv_init.rem_x = {mag_x, 31'd0} + 48'(root >> 1);
        dv_init.rem_y = {mag_y, 31'd0} + 48'(root >> 1);
        dv_init.rem_z = {mag_z, 31'd0} + 48'(root >> 1);
        dv_init.q_x   = 16'd0;
        dv_init.q_y   = 16'd0;
        dv_init.q_z   = 16'd0;
        dv_init.len   = root;
        dv_init.neg_x = sq_reg[flp_pkg::ISQRT_STAGES].x[15];
        dv_init.neg_y = sq_reg[flp_pkg::ISQRT_STAGES].y[15];
        dv_init.neg_z = sq_reg[flp_pkg::ISQRT_STAGES].z[15];
        dv_init.zero  = sq_reg[flp_pkg::ISQRT_STAGES].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= sq_valid_reg[flp_pkg::ISQRT_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv_init;
    end

    for (genvar j = 0; j < flp_pkg::DIV_STAGES; j++)
    begin : g_div
        localparam int QB = flp_pkg::DIV_STAGES - 1 - j;
        flp_pkg::div_t dv_next;
        logic [47:0]   dsor;

        always_comb
        begin
            dv_next = dv_reg[j];
            dsor    = {16'd0, dv_reg[j].len} << QB;
            if (dv_reg[j].rem_x >= dsor)
            begin
                dv_next.rem_x   = dv_reg[j].rem_x - dsor;
                dv_next.q_x[QB] = 1'b1;
            end
            if (dv_reg[j].rem_y >= dsor)
            begin
                dv_next.rem_y   = dv_reg[j].rem_y - dsor;
                dv_next.q_y[QB] = 1'b1;
            end
            if (dv_reg[j].rem_z >= dsor)
            begin
                dv_next.rem_z   = dv_reg[j].rem_z - dsor;
                dv_next.q_z[QB] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[j+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[j+1] <= dv_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[j+1] <= dv_next;
        end
    end

    // ---------------- dot product and reflection ----------------
    flp_pkg::div_t      dv_last;
    logic [15:0]        qc_x, qc_y, qc_z;
    logic signed [16:0] nx, ny, nz;

    always_comb
    begin
        dv_last = dv_reg[flp_pkg::DIV_STAGES];
        qc_x = (dv_last.q_x > flp_pkg::ONE_Q15) ? flp_pkg::ONE_Q15 : dv_last.q_x;
        qc_y = (dv_last.q_y > flp_pkg::ONE_Q15) ? flp_pkg::ONE_Q15 : dv_last.q_y;
        qc_z = (dv_last.q_z > flp_pkg::ONE_Q15) ? flp_pkg::ONE_Q15 : dv_last.q_z;
        nx = dv_last.neg_x ? -$signed({1'b0, qc_x}) : $signed({1'b0, qc_x});
        ny = dv_last.neg_y ? -$signed({1'b0, qc_y}) : $signed({1'b0, qc_y});
        nz = dv_last.neg_z ? -$signed({1'b0, qc_z}) : $signed({1'b0, qc_z});
    end

    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic signed [33:0] p1_px_reg, p1_py_reg, p1_pz_reg;
    logic signed [16:0] p1_nz_reg, p2_nz_reg;
    logic               p1_zero_reg, p2_zero_reg, p3_zero_reg, p4_zero_reg;
    logic signed [17:0] p2_dot_reg;
    logic signed [35:0] p3_prod_reg;
    logic [15:0]        p3_diff_reg, p4_diff_reg, p4_base_reg;
    logic signed [35:0] dot_sum, dot_round, rz_round;

    assign dot_sum   = 36'(p1_px_reg) + 36'(p1_py_reg) + 36'(p1_pz_reg);
    assign dot_round = flp_pkg::round15(dot_sum);
    assign rz_round  = flp_pkg::round15(p3_prod_reg) - 36'(flp_pkg::LIGHT_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= dv_valid_reg[flp_pkg::DIV_STAGES];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_px_reg   <= 34'(flp_pkg::LIGHT_X) * 34'(nx);
            p1_py_reg   <= 34'(flp_pkg::LIGHT_Y) * 34'(ny);
            p1_pz_reg   <= 34'(flp_pkg::LIGHT_Z) * 34'(nz);
            p1_nz_reg   <= nz;
            p1_zero_reg <= dv_last.zero;
            p2_dot_reg  <= dot_round[17:0];
            p2_nz_reg   <= p1_nz_reg;
            p2_zero_reg <= p1_zero_reg;
            p3_prod_reg <= 36'(p2_dot_reg * p2_nz_reg) <<< 1;
            p3_diff_reg <= p2_zero_reg ? 16'd0 : flp_pkg::clamp_unit(36'(p2_dot_reg));
            p3_zero_reg <= p2_zero_reg;
            p4_base_reg <= flp_pkg::clamp_unit(rz_round);
            p4_diff_reg <= p3_diff_reg;
            p4_zero_reg <= p3_zero_reg;
        end
    end

    // ---------------- power by repeated squaring ----------------
    flp_pkg::pow_t pw_reg [flp_pkg::POW_STAGES+1];
    logic          pw_valid_reg [flp_pkg::POW_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pw_valid_reg[0] <= 1'b0;
        else if (adv)
            pw_valid_reg[0] <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_reg[0].acc  <= flp_pkg::ONE_Q15;
            pw_reg[0].base <= p4_base_reg;
            pw_reg[0].diff <= p4_diff_reg;
            pw_reg[0].zero <= p4_zero_reg;
        end
    end

    for (genvar k = 0; k < flp_pkg::POW_STAGES; k++)
    begin : g_pow
        flp_pkg::pow_t pw_next;

        always_comb
        begin
            pw_next      = pw_reg[k];
            pw_next.base = flp_pkg::mul_q15(pw_reg[k].base, pw_reg[k].base);
            if (shininess_reg[k])
                pw_next.acc = flp_pkg::mul_q15(pw_reg[k].acc, pw_reg[k].base);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_valid_reg[k+1] <= 1'b0;
            else if (adv)
                pw_valid_reg[k+1] <= pw_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                pw_reg[k+1] <= pw_next;
        end
    end

    // ---------------- color sum ----------------
    flp_pkg::pow_t pw_last;
    logic [15:0]   spec;

    assign pw_last = pw_reg[flp_pkg::POW_STAGES];
    assign spec    = (pw_last.diff != 16'd0) ? pw_last.acc : 16'd0;

    logic        c1_valid_reg, c1_zero_reg;
    logic [30:0] c1_amb_reg [3];
    logic [31:0] c1_dif_reg [3];
    logic [31:0] c1_spc_reg [3];
    logic [15:0] chan_out [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [33:0] sum;
            logic [16:0] q;
            sum = 34'(c1_amb_reg[c]) + 34'(c1_dif_reg[c]) + 34'(c1_spc_reg[c]) + 34'd65536;
            q   = sum[33:17];
            chan_out[c] = q[16] ? 16'hFFFF : q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg <= pw_valid_reg[flp_pkg::POW_STAGES];
            out_valid    <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                c1_amb_reg[c] <= {ambient_reg[47-16*c -: 16], 15'd0};
                c1_dif_reg[c] <= 32'(diffuse_reg[47-16*c -: 16]) * 32'(pw_last.diff);
                c1_spc_reg[c] <= 32'(specular_reg[47-16*c -: 16]) * 32'(spec);
            end
            c1_zero_reg <= pw_last.zero;
            red         <= chan_out[0];
            green       <= chan_out[1];
            blue        <= chan_out[2];
            zero_normal <= c1_zero_reg;
        end
    end

    // ---------------- checks ----------------
    a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid_reg[flp_pkg::ISQRT_STAGES] |-> sq_reg[flp_pkg::ISQRT_STAGES].r[63:32] == 32'd0)
        else $error("square root exceeds 32 bits");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[flp_pkg::DIV_STAGES] && !dv_last.zero |-> dv_last.q_x <= flp_pkg::ONE_Q15)
        else $error("normalized component above one");

    a_pow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid_reg[flp_pkg::POW_STAGES] |-> pw_last.acc <= flp_pkg::ONE_Q15)
        else $error("specular power above one");

    a_zero_nodiff: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid_reg[flp_pkg::POW_STAGES] && pw_last.zero |-> pw_last.diff == 16'd0)
        else $error("diffuse term on zero normal");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(zero_normal))
        else $error("output changed under stall");

endmodule
